/* rtl/sip_pkg.sv */
// ---------------------------------------------------------------------------
// sip_pkg
// shared constants for the segment intersection point block
// ---------------------------------------------------------------------------
`default_nettype none
package sip_pkg;
  localparam int IN_BITS            = 16;
  localparam int OUT_BITS           = 24;
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int FRAC_BITS_DEFAULT  = 8;
endpackage
`default_nettype wire

/* rtl/segment_intersection_point.sv */
// ---------------------------------------------------------------------------
// segment_intersection_point
// pipelined intersection test and point of two 2d integer segments
// ---------------------------------------------------------------------------
// One segment pair per beat is taken every clock cycle while the output is not
// stalled, and one result beat leaves for each. The pipeline has seven stages
// of differences, cross and dot products, sums, denominator sign,
// classification and the scaling multiply, then one restoring divider stage
// per quotient bit, then an output stage that adds the start point and
// saturates. Each stage holds its beat while the next one is full and
// stalled, so bubbles close up under back-pressure. strict_interior is
// read live by the classification stage; write it only while idle.
`default_nettype none
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [IN_BITS-1:0]  a_start_x,
  input  wire logic signed [IN_BITS-1:0]  a_start_y,
  input  wire logic signed [IN_BITS-1:0]  a_end_x,
  input  wire logic signed [IN_BITS-1:0]  a_end_y,
  input  wire logic signed [IN_BITS-1:0]  b_start_x,
  input  wire logic signed [IN_BITS-1:0]  b_start_y,
  input  wire logic signed [IN_BITS-1:0]  b_end_x,
  input  wire logic signed [IN_BITS-1:0]  b_end_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            hit,
  output logic                            colinear_overlap,
  output logic                            degenerate,
  output logic signed [OUT_BITS-1:0]      point_x,
  output logic signed [OUT_BITS-1:0]      point_y
);
  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int CW  = C + 1;
  localparam int PW  = 2 * CW;
  localparam int W   = PW + 2;
  localparam int NW  = W - 1;
  localparam int HL  = (NW + 1) / 2;
  localparam int MW  = CW + NW;
  localparam int NNW = MW + F + 1;
  localparam int QW  = C + F + 1;
  localparam int VW  = (C + F + 3 > OUT_BITS) ? C + F + 3 : OUT_BITS + 1;
  localparam int NS  = 8 + QW;
  localparam longint OMAX = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
  localparam longint OMIN = -(64'sd1 <<< (OUT_BITS - 1));

  typedef struct packed {
    logic                hit;
    logic                col;
    logic                degen;
    logic                neg_x;
    logic                neg_y;
    logic signed [C-1:0] bx;
    logic signed [C-1:0] by;
  } meta_t;

  function automatic logic signed [C-1:0] crd(input logic [IN_BITS-1:0] v);
    logic [C+IN_BITS-1:0] z;
    z = {{C{1'b0}}, v};
    return $signed(z[C-1:0]);
  endfunction

  function automatic logic signed [CW-1:0] ext(input logic signed [C-1:0] v);
    return $signed({v[C-1], v});
  endfunction

  logic          strict_interior;
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_interior <= 1'b0;
    end else if (cfg_we) begin
      strict_interior <= cfg_wdata;
    end
  end

  always_comb begin
    adv[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: differences
  logic signed [C-1:0]  s1_px, s1_py;
  logic signed [CW-1:0] s1_rx, s1_ry, s1_sx, s1_sy, s1_wx, s1_wy;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_px <= crd(a_start_x);
      s1_py <= crd(a_start_y);
      s1_rx <= ext(crd(a_end_x)) - ext(crd(a_start_x));
      s1_ry <= ext(crd(a_end_y)) - ext(crd(a_start_y));
      s1_sx <= ext(crd(b_end_x)) - ext(crd(b_start_x));
      s1_sy <= ext(crd(b_end_y)) - ext(crd(b_start_y));
      s1_wx <= ext(crd(b_start_x)) - ext(crd(a_start_x));
      s1_wy <= ext(crd(b_start_y)) - ext(crd(a_start_y));
    end
  end

  // stage 2: products
  logic signed [C-1:0]  s2_px, s2_py;
  logic signed [CW-1:0] s2_rx, s2_ry;
  logic                 s2_degen;
  logic signed [PW-1:0] m_rxsy, m_rysx, m_wxry, m_wyrx, m_wxsy, m_wysx;
  logic signed [PW-1:0] m_rxrx, m_ryry, m_wxrx, m_wyry, m_sxrx, m_syry;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_px    <= s1_px;
      s2_py    <= s1_py;
      s2_rx    <= s1_rx;
      s2_ry    <= s1_ry;
      s2_degen <= (s1_rx == '0) && (s1_ry == '0);
      m_rxsy   <= s1_rx * s1_sy;
      m_rysx   <= s1_ry * s1_sx;
      m_wxry   <= s1_wx * s1_ry;
      m_wyrx   <= s1_wy * s1_rx;
      m_wxsy   <= s1_wx * s1_sy;
      m_wysx   <= s1_wy * s1_sx;
      m_rxrx   <= s1_rx * s1_rx;
      m_ryry   <= s1_ry * s1_ry;
      m_wxrx   <= s1_wx * s1_rx;
      m_wyry   <= s1_wy * s1_ry;
      m_sxrx   <= s1_sx * s1_rx;
      m_syry   <= s1_sy * s1_ry;
    end
  end

  // stage 3: cross and dot sums
  logic signed [C-1:0]  s3_px, s3_py;
  logic signed [CW-1:0] s3_rx, s3_ry;
  logic                 s3_degen;
  logic signed [W-1:0]  s3_den, s3_un, s3_tn, s3_rr, s3_d0, s3_sr;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_px    <= s2_px;
      s3_py    <= s2_py;
      s3_rx    <= s2_rx;
      s3_ry    <= s2_ry;
      s3_degen <= s2_degen;
      s3_den   <= W'(m_rxsy) - W'(m_rysx);
      s3_un    <= W'(m_wxry) - W'(m_wyrx);
      s3_tn    <= W'(m_wxsy) - W'(m_wysx);
      s3_rr    <= W'(m_rxrx) + W'(m_ryry);
      s3_d0    <= W'(m_wxrx) + W'(m_wyry);
      s3_sr    <= W'(m_sxrx) + W'(m_syry);
    end
  end

  // stage 4: sign of the denominator, far end of b along a
  logic signed [C-1:0]  s4_px, s4_py;
  logic signed [CW-1:0] s4_rx, s4_ry;
  logic                 s4_degen;
  logic signed [W-1:0]  s4_den, s4_un, s4_tn, s4_rr, s4_d0, s4_d1;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_px    <= s3_px;
      s4_py    <= s3_py;
      s4_rx    <= s3_rx;
      s4_ry    <= s3_ry;
      s4_degen <= s3_degen;
      s4_rr    <= s3_rr;
      s4_d0    <= s3_d0;
      s4_d1    <= s3_d0 + s3_sr;
      if (s3_den < 0) begin
        s4_den <= -s3_den;
        s4_un  <= -s3_un;
        s4_tn  <= -s3_tn;
      end else begin
        s4_den <= s3_den;
        s4_un  <= s3_un;
        s4_tn  <= s3_tn;
      end
    end
  end

  // stage 5: classification
  logic              c_hit, c_col;
  logic [NW-1:0]     c_num, c_dv;
  logic signed [W-1:0] c_lo;

  always_comb begin
    c_hit = 1'b0;
    c_col = 1'b0;
    c_num = '0;
    c_dv  = NW'(1);
    c_lo  = (s4_d0 < s4_d1) ? s4_d0 : s4_d1;
    if (s4_degen) begin
      c_hit = 1'b0;
    end else if (s4_den != '0) begin
      if (strict_interior) begin
        c_hit = (s4_un > 0) && (s4_un < s4_den) && (s4_tn > 0) && (s4_tn < s4_den);
      end else begin
        c_hit = (s4_un >= 0) && (s4_un <= s4_den) && (s4_tn >= 0) && (s4_tn <= s4_den);
      end
      if (c_hit) begin
        c_num = s4_tn[NW-1:0];
        c_dv  = s4_den[NW-1:0];
      end
    end else if (!strict_interior && (s4_un == '0)) begin
      c_dv = s4_rr[NW-1:0];
      if (s4_d0 < 0) begin
        c_hit = (s4_d1 >= 0);
      end else if (s4_d0 > s4_rr) begin
        c_hit = (s4_d1 <= s4_rr);
        c_num = s4_rr[NW-1:0];
      end else begin
        c_hit = 1'b1;
        c_num = (c_lo < 0) ? '0 : c_lo[NW-1:0];
      end
      c_col = c_hit;
      if (!c_hit) begin
        c_num = '0;
        c_dv  = NW'(1);
      end
    end
  end

  logic signed [C-1:0]  s5_px, s5_py;
  logic signed [CW-1:0] s5_rx, s5_ry;
  logic                 s5_hit, s5_col, s5_degen;
  logic [NW-1:0]        s5_num, s5_dv;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_px    <= s4_px;
      s5_py    <= s4_py;
      s5_rx    <= s4_rx;
      s5_ry    <= s4_ry;
      s5_hit   <= c_hit;
      s5_col   <= c_col;
      s5_degen <= s4_degen;
      s5_num   <= c_num;
      s5_dv    <= c_dv;
    end
  end

  // stage 6: partial products of |r| and the numerator
  logic [CW-1:0]      abs_x, abs_y;
  logic [CW+HL-1:0]   s6_xl, s6_yl;
  logic [MW-HL-1:0]   s6_xh, s6_yh;
  logic [NW-1:0]      s6_dv;
  meta_t              s6_meta;

  assign abs_x = s5_rx[CW-1] ? CW'(-s5_rx) : CW'(s5_rx);
  assign abs_y = s5_ry[CW-1] ? CW'(-s5_ry) : CW'(s5_ry);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_xl         <= abs_x * s5_num[HL-1:0];
      s6_xh         <= abs_x * s5_num[NW-1:HL];
      s6_yl         <= abs_y * s5_num[HL-1:0];
      s6_yh         <= abs_y * s5_num[NW-1:HL];
      s6_dv         <= s5_dv;
      s6_meta.hit   <= s5_hit;
      s6_meta.col   <= s5_col;
      s6_meta.degen <= s5_degen;
      s6_meta.neg_x <= s5_rx[CW-1];
      s6_meta.neg_y <= s5_ry[CW-1];
      s6_meta.bx    <= s5_px;
      s6_meta.by    <= s5_py;
    end
  end

  // stage 7 and divider: array index 0 is stage 7
  logic [NNW-1:0] rem_x [QW+1];
  logic [NNW-1:0] rem_y [QW+1];
  logic [QW-1:0]  quo_x [QW+1];
  logic [QW-1:0]  quo_y [QW+1];
  logic [NW-1:0]  dvs   [QW+1];
  meta_t          md    [QW+1];
  logic [MW-1:0]  prod_x, prod_y;

  assign prod_x = MW'(s6_xl) + (MW'(s6_xh) << HL);
  assign prod_y = MW'(s6_yl) + (MW'(s6_yh) << HL);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rem_x[0] <= (NNW'(prod_x) << F) + NNW'(s6_dv >> 1);
      rem_y[0] <= (NNW'(prod_y) << F) + NNW'(s6_dv >> 1);
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      dvs[0]   <= s6_dv;
      md[0]    <= s6_meta;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NNW:0] dsh;
    logic         ge_x, ge_y;
    logic [NNW:0] sub_x, sub_y;

    assign dsh   = (NNW + 1)'(dvs[j]) << B;
    assign ge_x  = {1'b0, rem_x[j]} >= dsh;
    assign ge_y  = {1'b0, rem_y[j]} >= dsh;
    assign sub_x = {1'b0, rem_x[j]} - dsh;
    assign sub_y = {1'b0, rem_y[j]} - dsh;

    always_ff @(posedge clk) begin
      if (adv[7+j]) begin
        rem_x[j+1] <= ge_x ? sub_x[NNW-1:0] : rem_x[j];
        rem_y[j+1] <= ge_y ? sub_y[NNW-1:0] : rem_y[j];
        quo_x[j+1] <= quo_x[j] | (QW'(ge_x) << B);
        quo_y[j+1] <= quo_y[j] | (QW'(ge_y) << B);
        dvs[j+1]   <= dvs[j];
        md[j+1]    <= md[j];
      end
    end
  end

  // output stage: add start point and saturate
  logic signed [VW-1:0] off_x, off_y, sum_x, sum_y;
  logic signed [VW-1:0] lim_hi, lim_lo;
  meta_t                mo;

  assign mo     = md[QW];
  assign lim_hi = VW'(OMAX);
  assign lim_lo = VW'(OMIN);
  assign off_x  = mo.neg_x ? -VW'($signed({1'b0, quo_x[QW]}))
                           : VW'($signed({1'b0, quo_x[QW]}));
  assign off_y  = mo.neg_y ? -VW'($signed({1'b0, quo_y[QW]}))
                           : VW'($signed({1'b0, quo_y[QW]}));
  assign sum_x  = (VW'(mo.bx) <<< F) + off_x;
  assign sum_y  = (VW'(mo.by) <<< F) + off_y;

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      hit              <= mo.hit;
      colinear_overlap <= mo.col;
      degenerate       <= mo.degen;
      if (!mo.hit) begin
        point_x <= '0;
        point_y <= '0;
      end else begin
        point_x <= (sum_x > lim_hi) ? lim_hi[OUT_BITS-1:0] :
                   (sum_x < lim_lo) ? lim_lo[OUT_BITS-1:0] : sum_x[OUT_BITS-1:0];
        point_y <= (sum_y > lim_hi) ? lim_hi[OUT_BITS-1:0] :
                   (sum_y < lim_lo) ? lim_lo[OUT_BITS-1:0] : sum_y[OUT_BITS-1:0];
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/sip_chk.sv */
// ---------------------------------------------------------------------------
// sip_chk
// port-level checks for segment_intersection_point
// ---------------------------------------------------------------------------
`default_nettype none
module sip_chk
  import sip_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       hit,
  input wire logic                       colinear_overlap,
  input wire logic                       degenerate,
  input wire logic signed [OUT_BITS-1:0] point_x,
  input wire logic signed [OUT_BITS-1:0] point_y
);
  // a miss beat carries a zero point and no overlap flag
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> point_x == '0 && point_y == '0 && !colinear_overlap)
    else $error("miss beat with nonzero point");

  a_degen_nohit: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !hit && !colinear_overlap)
    else $error("degenerate beat flagged as hit");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(point_x)
      && $stable(point_y) && $stable(degenerate))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");
endmodule

bind segment_intersection_point sip_chk u_sip_chk (.*);
`default_nettype wire

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// segment pairs in, hit flags and fixed-point point out, checked against an
// independent predictor; normal and strict modes, random bursts and stalls
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
  import sip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEFAULT;
  localparam int FB = FRAC_BITS_DEFAULT;
  localparam int LATENCY = 8 + CB + FB + 1;

  typedef struct {
    logic [IN_BITS-1:0] c[8];
  } seg_pair_t;

  typedef struct {
    logic                hit;
    logic                col;
    logic                degen;
    logic [OUT_BITS-1:0] px;
    logic [OUT_BITS-1:0] py;
  } crossing_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic longint to_coord(logic [IN_BITS-1:0] v);
    longint x;
    x = longint'(v[CB-1:0]);
    if (v[CB-1]) x -= (longint'(1) << CB);
    return x;
  endfunction

  // sign(rc) * round(|rc| * num * 2^FB / den), ties away from zero
  function automatic longint scaled_along(longint rc, longint num, longint den);
    logic [127:0] prod;
    logic [127:0] q;
    longint a;
    a = rc < 0 ? -rc : rc;
    prod = (128'(a) * 128'(num)) << FB;
    prod += 128'(den >> 1);
    q = prod / 128'(den);
    return rc < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [OUT_BITS-1:0] place_sat(longint base, longint off);
    longint v, hi, lo;
    v = base * (longint'(1) << FB) + off;
    hi = (longint'(1) << (OUT_BITS - 1)) - 1;
    lo = -(longint'(1) << (OUT_BITS - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_BITS-1:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s, logic strict_mode);
    crossing_t o;
    longint px, py, rx, ry, qx, qy, sx, sy, wx, wy, den, un, tn;
    longint rr, d0, d1, num, ox, oy;
    px = to_coord(s.c[0]); py = to_coord(s.c[1]);
    rx = to_coord(s.c[2]) - px; ry = to_coord(s.c[3]) - py;
    qx = to_coord(s.c[4]); qy = to_coord(s.c[5]);
    sx = to_coord(s.c[6]) - qx; sy = to_coord(s.c[7]) - qy;
    wx = qx - px; wy = qy - py;
    den = rx * sy - ry * sx;
    un = wx * ry - wy * rx;
    tn = wx * sy - wy * sx;
    o = '{hit: 0, col: 0, degen: 0, px: '0, py: '0};
    ox = 0; oy = 0;
    if (rx == 0 && ry == 0) begin
      o.degen = 1;
    end else if (den != 0) begin
      if (den < 0) begin
        den = -den; un = -un; tn = -tn;
      end
      if (strict_mode) o.hit = un > 0 && un < den && tn > 0 && tn < den;
      else o.hit = un >= 0 && un <= den && tn >= 0 && tn <= den;
      if (o.hit) begin
        ox = scaled_along(rx, tn, den);
        oy = scaled_along(ry, tn, den);
      end
    end else if (!strict_mode && un == 0) begin
      rr = rx * rx + ry * ry;
      d0 = wx * rx + wy * ry;
      d1 = d0 + (sx * rx + sy * ry);
      num = -1;
      if (d0 < 0) begin
        if (d1 >= 0) num = 0;
      end else if (d0 > rr) begin
        if (d1 <= rr) num = rr;
      end else begin
        num = d0 < d1 ? d0 : d1;
        if (num < 0) num = 0;
      end
      if (num >= 0) begin
        o.hit = 1; o.col = 1;
        ox = scaled_along(rx, num, rr);
        oy = scaled_along(ry, num, rr);
      end
    end
    if (o.hit) begin
      o.px = place_sat(px, ox);
      o.py = place_sat(py, oy);
    end
    return o;
  endfunction

  class crossing_scoreboard;
    crossing_t pending[$];
    logic strict_mode = 0;

    function void note_pair(seg_pair_t s);
      pending.push_back(predict_crossing(s, strict_mode));
    endfunction

    task check_result(crossing_t got);
      crossing_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) report("hit", got.hit, want.hit);
      if (got.col !== want.col) report("colinear_overlap", got.col, want.col);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
      if (got.px !== want.px) report("point_x", got.px, want.px);
      if (got.py !== want.py) report("point_y", got.py, want.py);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [IN_BITS-1:0] coord[8];
  logic out_valid;
  logic out_ready = 0;
  logic hit, colinear_overlap, degenerate;
  logic signed [OUT_BITS-1:0] point_x, point_y;

  crossing_scoreboard sb = new();
  int stall_mode = 0;

  initial coord = '{default: '0};

  always #10 clk = ~clk;

  segment_intersection_point u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_start_x(coord[0]), .a_start_y(coord[1]), .a_end_x(coord[2]),
    .a_end_y(coord[3]), .b_start_x(coord[4]), .b_start_y(coord[5]),
    .b_end_x(coord[6]), .b_end_y(coord[7]),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .colinear_overlap(colinear_overlap), .degenerate(degenerate),
    .point_x(point_x), .point_y(point_y)
  );

  // receiver stall pattern
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (stall_cnt % 7) < 3;
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    crossing_t got;
    if (!rst && out_valid && out_ready) begin
      got.hit = hit; got.col = colinear_overlap; got.degen = degenerate;
      got.px = point_x; got.py = point_y;
      sb.check_result(got);
    end
  end

  // valid stays high after the beat so that the next one can follow at once
  task automatic send_pair(seg_pair_t s);
    in_valid <= 1;
    coord <= s.c;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(s);
  endtask

  task automatic idle(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.strict_mode = v;
  endtask

  function automatic logic [IN_BITS-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return IN_BITS'($urandom_range(0, 20)) - IN_BITS'(10);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return IN_BITS'($urandom);
    endcase
  endfunction

  function automatic seg_pair_t rnd_pair();
    seg_pair_t s;
    int k, m;
    for (int i = 0; i < 8; i++) s.c[i] = rnd_coord();
    case ($urandom_range(0, 7))
      0: begin
        s.c[2] = s.c[0]; s.c[3] = s.c[1];
      end
      1, 2: begin
        // b on the line of a, at small multiples of a small direction
        k = $urandom_range(0, 6) - 3; m = $urandom_range(0, 6) - 3;
        s.c[0] = IN_BITS'($urandom_range(0, 200)) - IN_BITS'(100);
        s.c[1] = IN_BITS'($urandom_range(0, 200)) - IN_BITS'(100);
        s.c[2] = s.c[0] + IN_BITS'($urandom_range(0, 40)) - IN_BITS'(20);
        s.c[3] = s.c[1] + IN_BITS'($urandom_range(0, 40)) - IN_BITS'(20);
        s.c[6] = s.c[0] + IN_BITS'(m) * (s.c[2] - s.c[0]);
        s.c[7] = s.c[1] + IN_BITS'(m) * (s.c[3] - s.c[1]);
        s.c[4] = s.c[0] + IN_BITS'(k) * (s.c[2] - s.c[0]);
        s.c[5] = s.c[1] + IN_BITS'(k) * (s.c[3] - s.c[1]);
      end
      3: begin
        // parallel shifted copy
        for (int i = 0; i < 4; i++) s.c[4 + i] = s.c[i] + IN_BITS'(i % 2 ? 1 : 0);
      end
      4: begin
        for (int i = 0; i < 8; i++) s.c[i] = IN_BITS'($urandom_range(0, 64)) - IN_BITS'(32);
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic directed_pairs();
    seg_pair_t s;
    logic [IN_BITS-1:0] d[18][8];
    d = '{
      '{0, 0, 10, 10, 0, 10, 10, 0},
      '{0, 0, 10, 0, 10, 0, 10, 5},
      '{0, 0, 10, 0, 0, 0, 0, 5},
      '{0, 0, 10, 0, 5, 0, 20, 0},
      '{0, 0, 10, 0, -16'sd5, 0, 3, 0},
      '{0, 0, 10, 0, 20, 0, 5, 0},
      '{0, 0, 10, 0, 20, 0, 30, 0},
      '{0, 0, 10, 0, 0, 1, 10, 1},
      '{5, 5, 5, 5, 0, 0, 9, 9},
      '{0, 0, 3, 0, 1, -16'sd1, 2, 2},
      '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000},
      '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff},
      '{16'h8000, 0, 16'h7fff, 0, 16'h8000, 0, 16'h7fff, 0},
      '{0, 0, 3, 7, 3, 0, 0, 7},
      '{0, 0, -16'sd3, 1, -16'sd1, 0, -16'sd2, 1},
      '{0, 0, 10, 0, 10, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff}
    };
    foreach (d[i]) begin
      s.c = d[i];
      send_pair(s);
    end
  endtask

  task automatic random_pairs(int n);
    int gap;
    for (int sent = 0; sent < n;) begin
      for (int b = $urandom_range(1, 30); b > 0 && sent < n; b--) begin
        send_pair(rnd_pair());
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (gap != 0) idle(gap);
      if (sent == n / 2) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      stall_mode = phase;
      write_mode(phase % 2);
      directed_pairs();
      random_pairs(500);
      drain();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
rtl/sip_pkg.sv
rtl/segment_intersection_point.sv
rtl/sip_chk.sv
verif/testbench.sv
